// ===== hw/rtl/sha_pkg.sv =====
// sha_pkg: shared types, constants and round functions of the sha-256 hasher
// no dependencies
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load_byte;   // write byte into block buffer
    logic [5:0] byte_addr;
    logic [7:0] byte_data;
    logic       init_vars;   // working vars <- hash
    logic       round_en;    // run one round
    logic [5:0] round_idx;
    logic       fold;        // hash += working vars
    logic       reset_hash;  // hash <- initial values
    logic       shift_out;   // rotate hash words for output
  } sha_cmd_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t start_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher_top.sv =====
// sha256_stream_hasher_top: sha-256 over a byte stream, digest as eight words
// depends on sha_pkg, sha_ctrl, sha_dp
//
//  channel | dir | tdata            | tuser
//  in_     | in  | data_byte[7:0]   | byte_valid, end_of_message
//  out_    | out | digest_word[31:0]| word_index[2:0], last_word
//
// each accepted byte is written straight into the block buffer; the 64th byte of a block
// starts a compression (init, 64 rounds on the single shared round unit, fold)
// end of message: one pad write per remaining byte, one or two compressions,
// then eight words at one per cycle when out_tready is high
// input is stalled while a block is padded or compresses or the digest drains
// reset (rst_n low, synchronous) loads the initial hash and empties the buffer
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // byte_valid, end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [3:0]  out_tuser   // word_index[2:0], last_word
);
  import sha_pkg::*;

  sha_cmd_t   cmd;
  logic [2:0] idx;
  logic       last;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_index(idx), .out_last(last), .cmd
  );

  sha_dp u_dp (.clk, .rst_n, .cmd, .digest(out_tdata));

  assign out_tuser = {last, idx};
endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// sha_ctrl: sequencer for byte intake, padding, compression and digest output
// depends on sha_pkg
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [2:0]        out_index,
  output logic              out_last,
  output sha_pkg::sha_cmd_t cmd
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ROUND, S_FOLD, S_PAD, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] total_r, total_nxt;
  logic [5:0]  round_r, round_nxt;
  logic        fin_r, fin_nxt;     // message end pending
  logic        final_r, final_nxt; // current block holds the length
  logic        padded_r, padded_nxt; // pad byte already written
  logic [2:0]  oidx_r, oidx_nxt;
  logic        acc;

  assign in_tready  = (state_r == S_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_index  = oidx_r;
  assign out_last   = (oidx_r == 3'd7);

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    total_nxt  = total_r;
    round_nxt  = round_r;
    fin_nxt    = fin_r;
    final_nxt  = final_r;
    padded_nxt = padded_r;
    oidx_nxt   = oidx_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser[0]) begin
            cmd.load_byte = 1'b1;
            cmd.byte_addr = fill_r;
            cmd.byte_data = in_tdata;
            fill_nxt = fill_r + 6'd1;
          end
          fin_nxt    = in_tuser[1];
          padded_nxt = 1'b0;
          total_nxt  = bits_r + {55'd0, fill_r, 3'd0} + (in_tuser[0] ? 64'd8 : 64'd0);
          if (in_tuser[0] && fill_r == 6'd63) begin
            bits_nxt  = bits_r + 64'd512;
            final_nxt = 1'b0;
            state_nxt = S_INIT;
          end else if (in_tuser[1]) begin
            state_nxt = S_PAD;
            fill_nxt  = in_tuser[0] ? fill_r + 6'd1 : fill_r;
            round_nxt = 6'd0;  // pad step counter
          end
        end
      end
      S_PAD: begin
        // first step writes the pad byte at fill, then zeros / length to the block end
        cmd.load_byte = 1'b1;
        cmd.byte_addr = fill_r;
        if (round_r == 6'd0) cmd.byte_data = PadByte;
        else if (fill_r >= 6'd56 && final_r) cmd.byte_data =
          total_r[6'd63 - {fill_r[2:0], 3'd0} -: 8];
        else cmd.byte_data = 8'd0;
        round_nxt = 6'd1;
        fill_nxt  = fill_r + 6'd1;
        if (round_r == 6'd0) begin
          final_nxt  = (fill_r < 6'd56);
          padded_nxt = 1'b1;
        end
        if (fill_r == 6'd55 && (round_r != 6'd0 || fill_r < 6'd56)) final_nxt = 1'b1;
        if (fill_r == 6'd63) begin
          state_nxt = S_INIT;
          fin_nxt   = fin_r;
        end
      end
      S_INIT: begin
        cmd.init_vars = 1'b1;
        round_nxt = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en  = 1'b1;
        cmd.round_idx = round_r;
        round_nxt = round_r + 6'd1;
        if (round_r == 6'(Rounds - 1)) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        // a block filled by the last byte still needs the pad byte at the start
        round_nxt = padded_r ? 6'd1 : 6'd0;
        if (!fin_r) state_nxt = S_IDLE;
        else if (final_r) begin
          state_nxt = S_OUT;
          oidx_nxt  = 3'd0;
        end else begin
          state_nxt = S_PAD;
          fill_nxt  = 6'd0;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          cmd.shift_out = 1'b1;
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.reset_hash = 1'b1;
            state_nxt = S_IDLE;
            fill_nxt  = 6'd0;
            bits_nxt  = 64'd0;
            fin_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= 6'd0;
      bits_r   <= 64'd0;
      fin_r    <= 1'b0;
      final_r  <= 1'b0;
      padded_r <= 1'b0;
      oidx_r   <= 3'd0;
      round_r  <= 6'd0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bits_r   <= bits_nxt;
      fin_r    <= fin_nxt;
      final_r  <= final_nxt;
      padded_r <= padded_nxt;
      oidx_r   <= oidx_nxt;
      round_r  <= round_nxt;
    end
    total_r <= total_nxt;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load_byte, cmd.init_vars, cmd.round_en, cmd.fold}) <= 1)
    else $error("overlapping datapath commands");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(oidx_r))
    else $error("digest word dropped under stall");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> !in_tready)
    else $error("input taken during compression");
endmodule

// ===== hw/rtl/sha_dp.sv =====
// sha_dp: block buffer, message schedule, round unit and hash registers
// depends on sha_pkg
module sha_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_cmd_t cmd,
  output logic [31:0]       digest
);
  import sha_pkg::*;

  // block buffer held as big-endian words, byte 0 in the top lane of word 0
  word_t      blk_r [BlockBytes/4];
  word_t      w_r [16];
  word_t      v_r [8];
  word_t      h_r [8];
  word_t      w, s0, s1, t1, t2, a, e;

  always_comb begin
    a  = v_r[0];
    e  = v_r[4];
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    if (cmd.round_idx < 6'd16)
      w = blk_r[cmd.round_idx[3:0]];
    else
      w = s1 + w_r[9] + s0 + w_r[0];
    t1 = v_r[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
         + round_k(cmd.round_idx) + w;
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  assign digest = h_r[0];

  always_ff @(posedge clk) begin
    if (cmd.load_byte)
      blk_r[cmd.byte_addr[5:2]][{~cmd.byte_addr[1:0], 3'd0} +: 8] <= cmd.byte_data;
    if (cmd.init_vars) v_r <= h_r;
    if (cmd.round_en) begin
      // window shifts: w_r[15] newest
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= start_hash(3'(i));
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end else if (cmd.shift_out) begin
      // rotate for output; the last word reloads the initial hash
      if (cmd.reset_hash) begin
        for (int i = 0; i < 8; i++) h_r[i] <= start_hash(3'(i));
      end else begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
        h_r[7] <= h_r[0];
      end
    end
  end
endmodule
